@@ hdl/deic_pkg.sv @@
`default_nettype none
package deic_pkg;

  localparam int unsigned DIV_CELLS = 49;
  localparam int unsigned NUM_W     = 49;
  localparam logic [31:0] TIME_STEP_RESET = 32'h0010_0000;

  typedef struct packed {
    logic                  valid;
    logic                  zm;
    logic                  ov;
    logic [1:0]            neg;
    logic [31:0]           mass;
    logic [1:0][31:0]      pos;
    logic [1:0][31:0]      vel;
    logic [1:0][31:0]      drag;
    logic [1:0][31:0]      rem;
    logic [1:0][NUM_W-1:0] nq;
  } div_stage_t;

  typedef struct packed {
    logic             valid;
    logic             zm;
    logic             ov;
    logic [1:0][31:0] pos;
    logic [1:0][31:0] vel;
    logic [1:0][31:0] drag;
    logic [1:0][31:0] acc;
    logic [1:0][31:0] nvel;
    logic [1:0][31:0] npos;
  } tail_stage_t;

  // {overflow, value}
  function automatic logic [32:0] sat32(input logic signed [65:0] x);
    logic [32:0] r;
    if (x > 66'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (x < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/drag_euler_integrator_2d_unit.sv @@
// channel  | dir | signals                           | contents
// s_       | in  | s_tvalid s_tready s_tdata[255:0]  | one body
// m_       | out | m_tvalid m_tready m_tdata[263:0]  | updated body and flags
// cfg_     | in  | cfg_valid cfg_ready cfg_data[31:0]| time step
// One beat per cycle in and out when no output beat is stalled; the stages are
// one drag stage, a row of 49 divider cells (one quotient bit each), then
// acceleration, velocity and position stages. The whole row advances
// together; a stalled output beat holds every stage and drops s_tready. rst
// clears all valid bits and sets time_step to 16.0.
`default_nettype none
module drag_euler_integrator_2d_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output wire logic         s_tready,
  // pos_x, pos_y, vel_x, vel_y, force_x, force_y, body_mass, drag_coeff
  input  wire logic [255:0] s_tdata,
  output wire logic         m_tvalid,
  input  wire logic         m_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y, accel_x, accel_y, drag_x,
  // drag_y, overflow_flag, zero_mass_flag, 6 zero bits
  output wire logic [263:0] m_tdata,
  input  wire logic         cfg_valid,
  output wire logic         cfg_ready,
  input  wire logic [31:0]  cfg_data
);

  logic                  en;
  logic [31:0]           time_step;
  deic_pkg::div_stage_t  chain [0:deic_pkg::DIV_CELLS];
  deic_pkg::tail_stage_t res;

  assign en        = !res.valid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= deic_pkg::TIME_STEP_RESET;
    end else if (cfg_valid) begin
      time_step <= cfg_data;
    end
  end

  deic_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .q        (chain[0])
  );

  for (genvar i = 0; i < deic_pkg::DIV_CELLS; i++) begin : g_cell
    deic_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  deic_tail u_tail (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .time_step (time_step),
    .d         (chain[deic_pkg::DIV_CELLS]),
    .q         (res)
  );

  assign m_tvalid = res.valid;
  assign m_tdata  = {6'd0, res.zm, res.ov, res.drag[1], res.drag[0], res.acc[1], res.acc[0],
                     res.nvel[1], res.nvel[0], res.npos[1], res.npos[0]};

endmodule
`default_nettype wire

@@ hdl/deic_front.sv @@
`default_nettype none
module deic_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [255:0]            in_data,
  output deic_pkg::div_stage_t         q
);

  deic_pkg::div_stage_t d;

  always_comb begin
    logic [32:0]        vs;
    logic [32:0]        vm;
    logic [63:0]        prod;
    logic [48:0]        r;
    logic signed [65:0] dv;
    logic [32:0]        ds;
    logic [32:0]        t;
    logic [32:0]        tm;
    d       = '0;
    d.valid = in_valid;
    d.mass  = in_data[223:192];
    d.zm    = (d.mass == 32'd0);
    for (int k = 0; k < 2; k++) begin
      d.pos[k] = in_data[32*k +: 32];
      d.vel[k] = in_data[64 + 32*k +: 32];
      vs   = {d.vel[k][31], d.vel[k]};
      vm   = vs[32] ? (33'd0 - vs) : vs;
      prod = vm[31:0] * in_data[255:224];
      r    = 49'((prod + 64'd32768) >> 16);
      // drag opposes velocity
      dv   = d.vel[k][31] ? $signed({17'd0, r}) : -$signed({17'd0, r});
      ds   = deic_pkg::sat32(dv);
      d.drag[k] = ds[31:0];
      d.ov      = d.ov | ds[32];
      t    = {in_data[128 + 32*k + 31], in_data[128 + 32*k +: 32]}
           + {ds[31], ds[31:0]};
      tm   = t[32] ? (33'd0 - t) : t;
      d.neg[k] = t[32];
      d.rem[k] = '0;
      d.nq[k]  = {tm, 16'd0} + {17'd0, 1'b0, d.mass[31:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/deic_div_cell.sv @@
`default_nettype none
module deic_div_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire deic_pkg::div_stage_t d,
  output deic_pkg::div_stage_t      q
);

  deic_pkg::div_stage_t nxt;

  // one restoring quotient bit per lane
  always_comb begin
    logic [32:0] t;
    nxt = d;
    for (int k = 0; k < 2; k++) begin
      t = {d.rem[k], d.nq[k][deic_pkg::NUM_W-1]};
      if (t >= {1'b0, d.mass}) begin
        nxt.rem[k] = 32'(t - {1'b0, d.mass});
        nxt.nq[k]  = {d.nq[k][deic_pkg::NUM_W-2:0], 1'b1};
      end else begin
        nxt.rem[k] = t[31:0];
        nxt.nq[k]  = {d.nq[k][deic_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/deic_tail.sv @@
`default_nettype none
module deic_tail (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic [31:0]          time_step,
  input  wire deic_pkg::div_stage_t d,
  output deic_pkg::tail_stage_t     q
);

  deic_pkg::tail_stage_t s1, s1_next, s2, s2_next, s3_next;

  always_comb begin
    logic [32:0] a;
    s1_next       = '0;
    s1_next.valid = d.valid;
    s1_next.zm    = d.zm;
    s1_next.ov    = d.ov;
    s1_next.pos   = d.pos;
    s1_next.vel   = d.vel;
    s1_next.drag  = d.drag;
    for (int k = 0; k < 2; k++) begin
      a = deic_pkg::sat32(d.neg[k] ? -$signed({17'd0, d.nq[k]})
                                   : $signed({17'd0, d.nq[k]}));
      if (d.zm) begin
        s1_next.acc[k] = '0;
      end else begin
        s1_next.acc[k] = a[31:0];
        s1_next.ov     = s1_next.ov | a[32];
      end
    end
  end

  always_comb begin
    logic [31:0] am;
    logic [63:0] prod;
    logic [48:0] r;
    logic signed [65:0] sum;
    logic [32:0] nv;
    s2_next = s1;
    for (int k = 0; k < 2; k++) begin
      am   = s1.acc[k][31] ? (32'd0 - s1.acc[k]) : s1.acc[k];
      prod = am * time_step;
      r    = 49'((prod + 64'd32768) >> 16);
      sum  = $signed({{34{s1.vel[k][31]}}, s1.vel[k]})
           + (s1.acc[k][31] ? -$signed({17'd0, r}) : $signed({17'd0, r}));
      nv   = deic_pkg::sat32(sum);
      if (s1.zm) begin
        s2_next.nvel[k] = s1.vel[k];
      end else begin
        s2_next.nvel[k] = nv[31:0];
        s2_next.ov      = s2_next.ov | nv[32];
      end
    end
  end

  always_comb begin
    logic [32:0] s;
    logic [32:0] sm;
    logic [64:0] prod;
    logic [47:0] r;
    logic signed [65:0] sum;
    logic [32:0] np;
    s3_next = s2;
    for (int k = 0; k < 2; k++) begin
      s    = {s2.vel[k][31], s2.vel[k]} + {s2.nvel[k][31], s2.nvel[k]};
      sm   = s[32] ? (33'd0 - s) : s;
      prod = sm * {1'b0, time_step};
      // halve the velocity sum in the shift
      r    = 48'((prod + 65'd65536) >> 17);
      sum  = $signed({{34{s2.pos[k][31]}}, s2.pos[k]})
           + (s[32] ? -$signed({18'd0, r}) : $signed({18'd0, r}));
      np   = deic_pkg::sat32(sum);
      if (s2.zm) begin
        s3_next.npos[k] = s2.pos[k];
      end else begin
        s3_next.npos[k] = np[31:0];
        s3_next.ov      = s3_next.ov | np[32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      q.valid  <= 1'b0;
    end else if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      q  <= s3_next;
    end
  end

endmodule
`default_nettype wire

@@ sim/tb_drag_euler_integrator_2d_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_drag_euler_integrator_2d_unit;

  typedef struct packed {
    logic [31:0] kd;
    logic [31:0] mass;
    logic [31:0] fy;
    logic [31:0] fx;
    logic [31:0] vy;
    logic [31:0] vx;
    logic [31:0] py;
    logic [31:0] px;
  } body_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic        zm;
    logic        ov;
    logic [31:0] dy;
    logic [31:0] dx;
    logic [31:0] ay;
    logic [31:0] ax;
    logic [31:0] nvy;
    logic [31:0] nvx;
    logic [31:0] npy;
    logic [31:0] npx;
  } update_t;

  localparam int LATENCY = 53;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [255:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [263:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  drag_euler_integrator_2d_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  body_t   body_q[$];
  update_t update_q[$];
  logic [31:0] dt_model = 32'h0010_0000;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int beats_out = 0;
  longint cycles = 0;
  // acceptance seen at the last rising edge
  logic s_tready_q = 1'b0;

  function automatic logic signed [95:0] sat(input logic signed [95:0] x, ref bit ov);
    if (x > 96'sd2147483647) begin
      ov = 1;
      return 96'sd2147483647;
    end
    if (x < -96'sd2147483648) begin
      ov = 1;
      return -96'sd2147483648;
    end
    return x;
  endfunction

  // round(a*b / 2^sh) on the magnitude, ties away from zero
  function automatic logic signed [95:0] scale_rnd(input logic signed [95:0] a,
                                                   input logic [31:0] b, input int sh);
    logic [95:0] m;
    logic [95:0] r;
    m = a < 0 ? -a : a;
    r = (m * b + (96'd1 << (sh - 1))) >> sh;
    return a < 0 ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [95:0] div_rnd(input logic signed [95:0] t,
                                                 input logic [31:0] m);
    logic [95:0] mg;
    logic [95:0] q;
    mg = t < 0 ? -t : t;
    q = ((mg << 16) + (m >> 1)) / m;
    return t < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic update_t integrate(input body_t b, input logic [31:0] dt);
    update_t u;
    bit ov;
    logic signed [95:0] p, v, f, d, acc, nv, np;
    u = '0;
    ov = 0;
    for (int k = 0; k < 2; k++) begin
      p = $signed(k ? b.py : b.px);
      v = $signed(k ? b.vy : b.vx);
      f = $signed(k ? b.fy : b.fx);
      d = sat(scale_rnd(-v, b.kd, 16), ov);
      acc = 0;
      nv = v;
      np = p;
      if (b.mass != 0) begin
        acc = sat(div_rnd(f + d, b.mass), ov);
        nv = sat(v + scale_rnd(acc, dt, 16), ov);
        np = sat(p + scale_rnd(v + nv, dt, 17), ov);
      end
      if (k == 0) begin
        u.npx = np[31:0]; u.nvx = nv[31:0]; u.ax = acc[31:0]; u.dx = d[31:0];
      end else begin
        u.npy = np[31:0]; u.nvy = nv[31:0]; u.ay = acc[31:0]; u.dy = d[31:0];
      end
    end
    u.ov = ov;
    u.zm = (b.mass == 0);
    return u;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch beat %0d %s: got %h expected %h", beats_out, what, got, want);
    errors++;
  endtask

  task automatic add_body(input body_t b);
    body_q.insert(body_q.size(), b);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_q) begin
        if (body_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata <= body_q[0];
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    s_tready_q <= !rst && s_tvalid && s_tready;
    cycles <= cycles + 1;
    if (!rst && s_tvalid && s_tready) begin
      update_q.insert(update_q.size(), integrate(body_q.pop_front(), dt_model));
    end
    if (!rst && cfg_valid && cfg_ready) dt_model <= cfg_data;
  end

  // monitor
  always @(posedge clk) begin
    update_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (update_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = update_q.pop_front();
        if (got.npx !== want.npx) report_mismatch("new_pos_x", got.npx, want.npx);
        if (got.npy !== want.npy) report_mismatch("new_pos_y", got.npy, want.npy);
        if (got.nvx !== want.nvx) report_mismatch("new_vel_x", got.nvx, want.nvx);
        if (got.nvy !== want.nvy) report_mismatch("new_vel_y", got.nvy, want.nvy);
        if (got.ax !== want.ax) report_mismatch("accel_x", got.ax, want.ax);
        if (got.ay !== want.ay) report_mismatch("accel_y", got.ay, want.ay);
        if (got.dx !== want.dx) report_mismatch("drag_x", got.dx, want.dx);
        if (got.dy !== want.dy) report_mismatch("drag_y", got.dy, want.dy);
        if (got.ov !== want.ov)
          report_mismatch("overflow_flag", {31'd0, got.ov}, {31'd0, want.ov});
        if (got.zm !== want.zm)
          report_mismatch("zero_mass_flag", {31'd0, got.zm}, {31'd0, want.zm});
      end
      beats_out <= beats_out + 1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0004_0000);
      3: return -$urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_ufield();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h1;
      3: return $urandom_range(1, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic body_t rand_body();
    body_t b;
    b.px = rand_word(); b.py = rand_word();
    b.vx = rand_word(); b.vy = rand_word();
    b.fx = rand_word(); b.fy = rand_word();
    b.mass = rand_ufield();
    b.kd = rand_ufield();
    return b;
  endfunction

  task automatic drain();
    while (body_q.size() > 0 || update_q.size() > 0 || s_tvalid) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_step(input logic [31:0] dt);
    @(negedge clk);
    cfg_data <= dt;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) add_body(rand_body());
    drain();
  endtask

  initial begin
    body_t b;
    logic [31:0] ext[4];
    ext = '{32'h0, 32'h1, 32'h7fff_ffff, 32'h8000_0000};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // edge values at the reset step: zero mass, extremes, ties
    for (int i = 0; i < 4; i++) begin
      b = '{kd: ext[i], mass: ext[3 - i], fy: ext[i], fx: ext[3 - i],
            vy: ext[i], vx: ext[3 - i], py: ext[i], px: ext[3 - i]};
      add_body(b);
    end
    add_body('{kd: 32'hffff_ffff, mass: 32'h0, fy: 32'h0, fx: 32'h0,
               vy: 32'h8000_0000, vx: 32'h7fff_ffff, py: 32'h5, px: 32'h7});
    add_body('{kd: 32'h0001_0000, mass: 32'h0001_0000, fy: 32'hffff_fff8,
               fx: 32'h8, vy: 32'h1, vx: 32'hffff_ffff, py: 32'h0, px: 32'h0});
    add_body('{kd: 32'h0, mass: 32'h1, fy: 32'h7fff_ffff, fx: 32'h8000_0000,
               vy: 32'h0, vx: 32'h0, py: 32'h7fff_ffff, px: 32'h8000_0000});
    add_body('{kd: 32'h8000, mass: 32'hffff_ffff, fy: 32'h3, fx: 32'hffff_fffd,
               vy: 32'h1, vx: 32'hffff_ffff, py: 32'h1, px: 32'hffff_ffff});
    drain();
    for (int i = 0; i < 8; i++) add_body(rand_body());
    drain();

    write_step(32'h0);
    run_phase(100, 0, 0);
    write_step(32'hffff_ffff);
    run_phase(100, 76, 0);
    write_step(32'h0000_0001);
    run_phase(100, 0, 76);
    write_step(32'h0000_4000);
    run_phase(100, 27, 27);
    write_step($urandom);
    run_phase(150, 0, 0);
    write_step(32'h0001_0000);
    run_phase(150, 27, 27);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
